// ===== rtl/bgd_pkg.sv =====
package bgd_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_ENABLED       = 8'd0;
    localparam logic [7:0] CFG_DEBOUNCE_MS   = 8'd1;
    localparam logic [7:0] CFG_DOUBLE_GAP_MS = 8'd2;
    localparam logic [7:0] CFG_LONG_PRESS_MS = 8'd3;

    // Register values after reset.
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd25;
    localparam logic [15:0] DOUBLE_GAP_RESET = 16'd400;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;

    // One result item.
    typedef struct packed {
        logic pressed;
        logic long_press;
        logic double_tap;
        logic single_tap;
    } t_result;

endpackage

// ===== rtl/button_gesture_detector.sv =====
// An accepted input item passes through the input register and then the result register to reach the master side.
// Throughput: one item per clock while the master side accepts results; the state update
// for a poll completes in the single compute stage, so the next poll can follow directly behind it.
// Reset (i_rst_n low, synchronous): the button is taken as released, all gesture
// state is cleared, the block is disabled and the timing registers return to 25/400/2000 ms.
module button_gesture_detector #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream. tdata: [31:0] now_ms, [32] raw_pressed, [39:33] zero.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [39:0]            i_s_tdata,
    // Result stream. tdata: [0] single_tap, [1] double_tap, [2] long_press,
    // [3] pressed, [7:4] zero.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);
    import bgd_pkg::*;

    localparam int TW = TIME_WIDTH;

    // Configuration registers.
    logic        r_enabled;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_double_gap_ms;
    logic [15:0] r_long_press_ms;

    // Input register stage.
    logic          r_in_valid;
    logic [TW-1:0] r_in_now;
    logic          r_in_raw;

    // Gesture state.
    logic          r_last_raw,       n_last_raw;
    logic          r_stable_level,   n_stable_level;
    logic [TW-1:0] r_settle_start,   n_settle_start;
    logic          r_awaiting,       n_awaiting;
    logic [TW-1:0] r_first_release,  n_first_release;
    logic [TW-1:0] r_single_deadline, n_single_deadline;
    logic [TW-1:0] r_press_start,    n_press_start;
    logic          r_long_fired,     n_long_fired;

    // Result register stage.
    logic    r_out_valid;
    t_result r_out, n_out;

    logic advance;

    // Configuration writes are always taken; the user must send them only while idle; nothing enforces it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= 1'b0;
            r_debounce_ms   <= DEBOUNCE_RESET;
            r_double_gap_ms <= DOUBLE_GAP_RESET;
            r_long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLED:       r_enabled       <= i_cfg_data[0];
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                CFG_DOUBLE_GAP_MS: r_double_gap_ms <= i_cfg_data;
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                default: ;  // Indexes beyond the register list are ignored.
            endcase
        end
    end

    // The compute stage moves when it holds an item and the result register is free
    // or is being emptied in this cycle. The input register refills behind it.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // The timestamp is zero-extended and then cut to the internal time width on the way in.
    logic [63:0] now_ext;
    assign now_ext = {32'b0, i_s_tdata[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_now <= now_ext[TW-1:0];
            r_in_raw <= i_s_tdata[32];
        end
    end

    // Time values widened to the internal time width for compares and the deadline sum.
    logic [63:0]   debounce_ext, gap_ext, long_ext;
    logic [TW-1:0] debounce_t, gap_t, long_t;
    assign debounce_ext = {48'b0, r_debounce_ms};
    assign gap_ext      = {48'b0, r_double_gap_ms};
    assign long_ext     = {48'b0, r_long_press_ms};
    assign debounce_t   = debounce_ext[TW-1:0];
    assign gap_t        = gap_ext[TW-1:0];
    assign long_t       = long_ext[TW-1:0];

    // Wrap-around differences from the current time; all arithmetic is modulo 2^TW.
    logic [TW-1:0] since_deadline, since_press, since_settle, since_release;
    assign since_deadline = r_in_now - r_single_deadline;
    assign since_press    = r_in_now - r_press_start;
    assign since_settle   = r_in_now - r_settle_start;

    // Pending-tap state after the single tap check, which the release logic sees.
    logic          single_fire, long_fire;
    logic          aw_mid;
    logic [TW-1:0] frt_mid, sd_mid;
    logic          lf_mid;

    assign since_release = r_in_now - frt_mid;

    always_comb begin
        // A deadline of zero means no tap is pending.
        single_fire = (r_single_deadline != '0) && r_awaiting && !since_deadline[TW-1];
        aw_mid  = single_fire ? 1'b0 : r_awaiting;
        frt_mid = single_fire ? '0   : r_first_release;
        sd_mid  = single_fire ? '0   : r_single_deadline;

        // A press that settled at time zero never turns into a long press.
        long_fire = r_stable_level && !r_long_fired && (r_press_start != '0) &&
                    (since_press >= long_t);
        lf_mid = r_long_fired || long_fire;
    end

    always_comb begin
        n_last_raw        = r_last_raw;
        n_stable_level    = r_stable_level;
        n_settle_start    = r_settle_start;
        n_awaiting        = r_awaiting;
        n_first_release   = r_first_release;
        n_single_deadline = r_single_deadline;
        n_press_start     = r_press_start;
        n_long_fired      = r_long_fired;
        n_out             = '0;

        if (r_enabled) begin
            n_awaiting        = aw_mid;
            n_first_release   = frt_mid;
            n_single_deadline = sd_mid;
            n_long_fired      = lf_mid;
            n_out.single_tap  = single_fire;
            n_out.long_press  = long_fire;

            if (r_in_raw != r_last_raw) begin
                // Any raw change restarts the settle timer.
                n_last_raw     = r_in_raw;
                n_settle_start = r_in_now;
            end else if ((since_settle >= debounce_t) && (r_stable_level != r_in_raw)) begin
                n_stable_level = r_in_raw;
                if (!r_stable_level) begin
                    n_press_start = r_in_now;
                end else begin
                    priority if (lf_mid) begin
                        // Release after a long press ends it quietly.
                        n_long_fired      = 1'b0;
                        n_awaiting        = 1'b0;
                        n_first_release   = '0;
                        n_single_deadline = '0;
                    end else if (aw_mid && (frt_mid != '0) && (since_release < gap_t)) begin
                        n_out.double_tap  = 1'b1;
                        n_awaiting        = 1'b0;
                        n_first_release   = '0;
                        n_single_deadline = '0;
                    end else begin
                        // First release: arm the single tap deadline.
                        n_first_release   = r_in_now;
                        n_awaiting        = 1'b1;
                        n_single_deadline = r_in_now + gap_t;
                    end
                    n_press_start = '0;
                end
            end
            n_out.pressed = n_stable_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw        <= 1'b0;
            r_stable_level    <= 1'b0;
            r_settle_start    <= '0;
            r_awaiting        <= 1'b0;
            r_first_release   <= '0;
            r_single_deadline <= '0;
            r_press_start     <= '0;
            r_long_fired      <= 1'b0;
        end else if (advance) begin
            r_last_raw        <= n_last_raw;
            r_stable_level    <= n_stable_level;
            r_settle_start    <= n_settle_start;
            r_awaiting        <= n_awaiting;
            r_first_release   <= n_first_release;
            r_single_deadline <= n_single_deadline;
            r_press_start     <= n_press_start;
            r_long_fired      <= n_long_fired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out};

`ifndef NO_ASSERTIONS
    // A single tap clears the pending tap, so a double tap cannot follow in the same poll.
    a_tap_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.single_tap && r_out.double_tap))
        else $error("single and double tap reported together");

    // A long press fired in a poll swallows the release in that same poll.
    a_long_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.long_press && r_out.double_tap))
        else $error("long press and double tap reported together");

    // Long press can only be latched while the settled level is pressed.
    a_long_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_fired |-> r_stable_level)
        else $error("long press latched while released");

    // With no tap pending, the release time and the deadline are both cleared.
    a_pending_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_awaiting |-> (r_single_deadline == '0) && (r_first_release == '0))
        else $error("stale pending tap data");
`endif

endmodule
